// ===== src/plb_pkg.sv =====
// ============================================================================
// plb_pkg
// Shared types and status codes for the price level book.
// ============================================================================
package plb_pkg;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Broadcast command from the side controller to every cell of a side.
    typedef struct packed {
        logic        go;      // apply this update in the current cycle
        logic        remove;  // 1 remove, 0 add
        logic        ask;     // ordering of this side: ask sorts ascending
        logic [31:0] price;
        logic [31:0] volume;
    } t_cmd;

    // Per-cell summary reported back to the controller.
    typedef struct packed {
        logic occupied;
        logic hit;            // occupied and price equal
        logic behind;         // occupied and the command price ranks ahead
    } t_cell_flags;

endpackage

// ===== src/price_level_book.sv =====
// ============================================================================
// price_level_book
// Bid and ask price level tables kept sorted in cell chains, best level first.
// ============================================================================
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | operation, side, price, volume
//  result  | out       | o_valid / i_ready  | status, best bid/ask, counts
//
//  An update is captured in the input registers, then the cell chain of its side
//  is searched and shifted in the work state, after which the result is shown.
//  A new update is taken while idle or while the shown result is drained.
//  Reset clears the level counts and cell occupancy.
//  A stalled result holds the chains and status; the input waits until it is taken.
module price_level_book
    import plb_pkg::*;
#(
    parameter int LEVELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic        i_book_side,
    input  logic [31:0] i_level_price,
    input  logic [31:0] i_volume,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_bid_valid,
    output logic [31:0] o_best_bid_price,
    output logic [31:0] o_best_bid_size,
    output logic        o_ask_valid,
    output logic [31:0] o_best_ask_price,
    output logic [31:0] o_best_ask_size,
    output logic [4:0]  o_bid_level_count,
    output logic [4:0]  o_ask_level_count
);

    localparam int CW = $clog2(LEVELS + 1);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WORK = 2'd1;
    localparam logic [1:0] S_SHOW = 2'd2;

    logic [1:0]  r_state;
    logic        r_op;
    logic        r_side;
    logic [31:0] r_price;
    logic [31:0] r_vol;
    logic [1:0]  r_status;
    t_cmd        w_bid_cmd;
    t_cmd        w_ask_cmd;
    logic        w_bid_found, w_bid_full;
    logic        w_ask_found, w_ask_full;
    logic [31:0] w_bid_price, w_bid_size, w_ask_price, w_ask_size;
    logic [CW-1:0] w_bid_count, w_ask_count;
    logic        w_found;
    logic        w_full;
    logic        w_accept;

    assign o_ready  = (r_state == S_IDLE) || (r_state == S_SHOW && i_ready);
    assign w_accept = i_valid && o_ready;

    assign w_bid_cmd.go     = (r_state == S_WORK) && !r_side;
    assign w_bid_cmd.remove = r_op;
    assign w_bid_cmd.ask    = 1'b0;
    assign w_bid_cmd.price  = r_price;
    assign w_bid_cmd.volume = r_vol;
    assign w_ask_cmd.go     = (r_state == S_WORK) && r_side;
    assign w_ask_cmd.remove = r_op;
    assign w_ask_cmd.ask    = 1'b1;
    assign w_ask_cmd.price  = r_price;
    assign w_ask_cmd.volume = r_vol;

    plb_side #(.LEVELS(LEVELS)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_bid_cmd),
        .o_found(w_bid_found), .o_full(w_bid_full),
        .o_best_price(w_bid_price), .o_best_size(w_bid_size),
        .o_count(w_bid_count)
    );
    plb_side #(.LEVELS(LEVELS)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_ask_cmd),
        .o_found(w_ask_found), .o_full(w_ask_full),
        .o_best_price(w_ask_price), .o_best_size(w_ask_size),
        .o_count(w_ask_count)
    );

    assign w_found = r_side ? w_ask_found : w_bid_found;
    assign w_full  = r_side ? w_ask_full  : w_bid_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (w_accept) r_state <= S_WORK;
                S_WORK: r_state <= S_SHOW;
                S_SHOW: begin
                    if (w_accept) begin
                        r_state <= S_WORK;
                    end else if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (w_accept) begin
            r_op    <= i_operation;
            r_side  <= i_book_side;
            r_price <= i_level_price;
            r_vol   <= i_volume;
        end
        if (r_state == S_WORK) begin
            if (r_op) begin
                r_status <= w_found ? ST_DONE : ST_NOTFOUND;
            end else begin
                r_status <= (!w_found && w_full) ? ST_FULL : ST_DONE;
            end
        end
    end

    // Cells and counts settle at the end of the work cycle, so the result
    // is read straight from the chains while it is shown.
    assign o_valid           = (r_state == S_SHOW);
    assign o_status          = r_status;
    assign o_bid_valid       = (w_bid_count != '0);
    assign o_best_bid_price  = o_bid_valid ? w_bid_price : 32'd0;
    assign o_best_bid_size   = o_bid_valid ? w_bid_size  : 32'd0;
    assign o_ask_valid       = (w_ask_count != '0);
    assign o_best_ask_price  = o_ask_valid ? w_ask_price : 32'd0;
    assign o_best_ask_size   = o_ask_valid ? w_ask_size  : 32'd0;
    assign o_bid_level_count = 5'(w_bid_count);
    assign o_ask_level_count = 5'(w_ask_count);

`ifndef SYNTH
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_bid_cmd.go && w_ask_cmd.go))
        else $error("both sides updated at once");
    a_show_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WORK) |=> (r_state == S_SHOW))
        else $error("work cycle not followed by result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_status))
        else $error("stalled result changed");
`endif

endmodule

// ===== src/plb_cell.sv =====
// ============================================================================
// plb_cell
// One level slot of a sorted side. Holds price, size and occupancy, and
// takes its left neighbor's entry on insert or its right neighbor's on delete.
// ============================================================================
module plb_cell
    import plb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    // Left neighbor (toward the best end). The side ties the best cell's left
    // neighbor to occupied and not behind, so a new best level lands there.
    input  logic        i_left_occ,
    input  logic        i_left_behind,
    input  logic [31:0] i_left_price,
    input  logic [31:0] i_left_size,
    // Right neighbor.
    input  logic        i_right_occ,
    input  logic [31:0] i_right_price,
    input  logic [31:0] i_right_size,
    // A cell to the left is deleted by the current removal.
    input  logic        i_del_left_any,
    // The price already exists on this side or the side is full.
    input  logic        i_no_insert,
    output t_cell_flags o_flags,
    output logic        o_del_left_any,
    output logic [31:0] o_price,
    output logic [31:0] o_size
);

    logic        r_occ;
    logic [31:0] r_price;
    logic [31:0] r_size;
    logic        n_occ;
    logic [31:0] n_price;
    logic [31:0] n_size;
    logic        w_hit;
    logic        w_behind;
    logic        w_left_stays;
    logic [32:0] w_sum;
    logic        w_del;
    logic        w_shift_left;

    assign w_hit    = r_occ && (r_price == i_cmd.price);
    assign w_behind = r_occ && (i_cmd.ask ? (i_cmd.price < r_price)
                                          : (i_cmd.price > r_price));
    assign w_sum    = {1'b0, r_size} + {1'b0, i_cmd.volume};
    // The matched cell is deleted when the removal covers its size.
    assign w_del    = w_hit && (r_size <= i_cmd.volume);
    // The deleted cell and every cell right of it take their right neighbor's entry.
    assign w_shift_left = i_del_left_any || w_del;
    // The left neighbor keeps its place when it is not behind the new price.
    assign w_left_stays = i_left_occ && !i_left_behind;

    always_comb begin
        n_occ   = r_occ;
        n_price = r_price;
        n_size  = r_size;
        if (i_cmd.go) begin
            if (i_cmd.remove) begin
                if (w_hit && !w_del) begin
                    n_size = r_size - i_cmd.volume;
                end else if (w_shift_left) begin
                    n_occ   = i_right_occ;
                    n_price = i_right_price;
                    n_size  = i_right_size;
                end
            end else if (w_hit) begin
                n_size = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
            end else if (!i_no_insert) begin
                if (w_behind || !r_occ) begin
                    if (w_left_stays) begin
                        n_occ   = 1'b1;
                        n_price = i_cmd.price;
                        n_size  = i_cmd.volume;
                    end else if (i_left_occ) begin
                        n_occ   = i_left_occ;
                        n_price = i_left_price;
                        n_size  = i_left_size;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_price <= n_price;
        r_size  <= n_size;
    end

    assign o_flags.occupied = r_occ;
    assign o_flags.hit      = w_hit;
    assign o_flags.behind   = w_behind;
    assign o_del_left_any   = i_del_left_any || w_del;
    assign o_price          = r_price;
    assign o_size           = r_size;

endmodule

// ===== src/plb_side.sv =====
// ============================================================================
// plb_side
// A chain of level cells for one side of the book, with its level count.
// ============================================================================
module plb_side
    import plb_pkg::*;
#(
    parameter int LEVELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output logic        o_found,
    output logic        o_full,
    output logic [31:0] o_best_price,
    output logic [31:0] o_best_size,
    output logic [$clog2(LEVELS+1)-1:0] o_count
);

    localparam int CW = $clog2(LEVELS + 1);

    t_cell_flags w_flags [LEVELS];
    logic        w_del_chain [LEVELS+1];
    logic [31:0] w_price [LEVELS];
    logic [31:0] w_size  [LEVELS];
    logic        w_found;
    logic        w_no_insert;
    logic        w_del_any;
    logic [LEVELS-1:0] w_del_vec;
    logic [LEVELS-1:0] w_hit_vec;
    logic [CW-1:0] r_count;

    assign w_del_chain[0] = 1'b0;
    assign w_found     = |w_hit_vec;
    // A full side takes no new level, so nothing may shift on a dropped add.
    assign w_no_insert = w_found || w_flags[LEVELS-1].occupied;

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_cell
            logic        l_occ;
            logic        l_behind;
            logic [31:0] l_price;
            logic [31:0] l_size;
            logic        rt_occ;
            logic [31:0] rt_price;
            logic [31:0] rt_size;
            if (g == 0) begin : g_first
                assign l_occ    = 1'b1;
                assign l_behind = 1'b0;
                assign l_price  = '0;
                assign l_size   = '0;
            end else begin : g_mid
                assign l_occ    = w_flags[g-1].occupied;
                assign l_behind = w_flags[g-1].behind;
                assign l_price  = w_price[g-1];
                assign l_size   = w_size[g-1];
            end
            if (g == LEVELS - 1) begin : g_last
                assign rt_occ   = 1'b0;
                assign rt_price = '0;
                assign rt_size  = '0;
            end else begin : g_inner
                assign rt_occ   = w_flags[g+1].occupied;
                assign rt_price = w_price[g+1];
                assign rt_size  = w_size[g+1];
            end
            plb_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_cmd         (i_cmd),
                .i_left_occ    (l_occ),
                .i_left_behind (l_behind),
                .i_left_price  (l_price),
                .i_left_size   (l_size),
                .i_right_occ   (rt_occ),
                .i_right_price (rt_price),
                .i_right_size  (rt_size),
                .i_del_left_any(w_del_chain[g]),
                .i_no_insert   (w_no_insert),
                .o_flags       (w_flags[g]),
                .o_del_left_any(w_del_chain[g+1]),
                .o_price       (w_price[g]),
                .o_size        (w_size[g])
            );
            assign w_hit_vec[g] = w_flags[g].hit;
            assign w_del_vec[g] = w_flags[g].hit && (w_size[g] <= i_cmd.volume);
        end
    endgenerate

    assign w_del_any = |w_del_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.go) begin
            if (i_cmd.remove) begin
                if (w_del_any) begin
                    r_count <= r_count - CW'(1);
                end
            end else if (!w_found && !w_flags[LEVELS-1].occupied) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    assign o_found      = w_found;
    assign o_full       = w_flags[LEVELS-1].occupied;
    assign o_best_price = w_price[0];
    assign o_best_size  = w_size[0];
    assign o_count      = r_count;

`ifndef SYNTH
    a_count_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !w_flags[0].occupied)
        else $error("level count disagrees with occupancy of best cell");
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_del_vec))
        else $error("more than one level matched a price");
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_flags[LEVELS-1].occupied == (r_count == CW'(LEVELS)))
        else $error("full flag disagrees with level count");
`endif

endmodule
